// ===== rtl/tqlod_pkg.sv =====
// ----------------------------------------------------------------------------
// tqlod_pkg
// Shared widths, reset values, register indexes, types and the threshold step
// of the terrain quadtree LOD classifier.
// ----------------------------------------------------------------------------
package tqlod_pkg;

    localparam int unsigned COORD_W   = 24;
    localparam int unsigned LVL_W     = 4;
    localparam int unsigned DIST_W    = 25;
    localparam int unsigned RAD_W     = 2 * DIST_W;
    localparam int unsigned THR_W     = 32;
    localparam int unsigned LIM_W     = 26;
    localparam int unsigned MUL_W     = 12;
    localparam int unsigned MR_W      = 9;
    localparam int unsigned IDX_W     = 3;
    localparam int unsigned CFG_W     = 24;
    localparam int unsigned IN_TDATA_W  = 128;
    localparam int unsigned OUT_TDATA_W = 72;

    localparam int unsigned MAX_LEVEL_DEF = 15;

    localparam logic [23:0]      WORLD_SIZE_RST = 24'd262144;
    localparam logic [23:0]      BASE_DIST_RST  = 24'd25600;
    localparam logic [MUL_W-1:0] MULT_RST       = 12'd512;
    localparam logic [MR_W-1:0]  MORPH_RANGE_RST = 9'd77;
    localparam logic             MORPH_EN_RST   = 1'b1;

    localparam logic [MR_W-1:0]  ONE_FX  = 9'd256;
    localparam logic [MUL_W-1:0] MUL_ONE = 12'd256;

    typedef enum logic [IDX_W-1:0] {
        CFG_WORLD_SIZE  = 3'd0,
        CFG_BASE_DIST   = 3'd1,
        CFG_MULTIPLIER  = 3'd2,
        CFG_MORPH_RANGE = 3'd3,
        CFG_MORPH_EN    = 3'd4
    } t_cfg_idx;

    // Sideband that travels beside the square root
    typedef struct packed {
        logic [LVL_W-1:0] lvl;
        logic [THR_W-1:0] t;
        logic [THR_W-1:0] thr;
        logic [THR_W-1:0] nxt;
        logic [LIM_W-1:0] lim;
    } t_side;

    // Morph division state
    typedef struct packed {
        logic              vis;
        logic              split;
        logic [DIST_W-1:0] cdist;
        logic [THR_W-1:0]  thr;
        logic              act;
        logic              full;
        logic [THR_W-1:0]  den;
        logic [THR_W-1:0]  rem;
        logic [7:0]        q;
    } t_div;

    // One level of threshold growth, saturated to 32 bits
    function automatic logic [THR_W-1:0] thr_step(input logic [THR_W-1:0] t,
                                                 input logic [MUL_W-1:0] m);
        logic [THR_W+MUL_W-1:0] p;
        p = {{MUL_W{1'b0}}, t} * {{THR_W{1'b0}}, m};
        if (|p[THR_W+MUL_W-1:THR_W+8]) begin
            return '1;
        end
        return p[THR_W+7:8];
    endfunction

endpackage

// ===== rtl/tqlod_stage.sv =====
// ----------------------------------------------------------------------------
// tqlod_stage
// One pipeline stage: one bit of the distance square root and, where STEP is
// nonzero, one level of threshold growth.
// ----------------------------------------------------------------------------
module tqlod_stage import tqlod_pkg::*; #(
    parameter int unsigned BIT  = 0,
    parameter int unsigned STEP = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [MUL_W-1:0]  i_mult,
    input  logic              i_vld,
    input  logic [RAD_W-1:0]  i_rem,
    input  logic [DIST_W-1:0] i_root,
    input  t_side             i_side,
    output logic              o_vld,
    output logic [RAD_W-1:0]  o_rem,
    output logic [DIST_W-1:0] o_root,
    output t_side             o_side
);

    localparam int unsigned TRIAL_W = RAD_W + 2;

    logic [TRIAL_W-1:0] w_trial;
    logic [RAD_W-1:0]   n_rem;
    logic [DIST_W-1:0]  n_root;
    logic [THR_W-1:0]   w_tn;
    t_side              n_side;
    logic               r_vld;
    logic [RAD_W-1:0]   r_rem;
    logic [DIST_W-1:0]  r_root;
    t_side              r_side;

    always_comb begin
        w_trial = (TRIAL_W'(i_root) << (BIT + 1)) + (TRIAL_W'(1) << (2 * BIT));
        if ({2'b00, i_rem} >= w_trial) begin
            n_rem  = i_rem - w_trial[RAD_W-1:0];
            n_root = i_root | (DIST_W'(1) << BIT);
        end else begin
            n_rem  = i_rem;
            n_root = i_root;
        end
    end

    always_comb begin
        n_side = i_side;
        w_tn   = thr_step(i_side.t, i_mult);
        if (STEP != 0) begin
            n_side.t = w_tn;
            if (i_side.lvl == LVL_W'(STEP)) begin
                n_side.thr = w_tn;
            end
            if ({1'b0, i_side.lvl} == (LVL_W+1)'(STEP + 1)) begin
                n_side.nxt = w_tn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= n_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_side = r_side;

endmodule

// ===== rtl/terrain_quad_lod_classifier.sv =====
// Throughput: one node per cycle; every stage is registered and the whole pipe
// advances together whenever the output register is empty or being taken.
// Stages: 3 front (difference, squares, sum), 25 square root bits with the
// threshold chain alongside, 4 morph start, 1 setup, 8 quotient bits, 1 output.
// Reset (synchronous, active low) clears all valid bits and loads the
// configuration registers with their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// terrain_quad_lod_classifier
// Quadtree node LOD classifier: distance cull, split decision and geomorph
// factor for one node per cycle while the pipe advances.
// ----------------------------------------------------------------------------
module terrain_quad_lod_classifier import tqlod_pkg::*; #(
    parameter int unsigned MAX_LEVEL = MAX_LEVEL_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config write port
    input  logic                   i_cfg_we,
    input  logic [IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // node stream in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // node_x, node_z, node_size, node_level, cam_x, cam_z (lowest first)
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // result stream out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // visible, subdivide, cam_distance, level_threshold, morph_factor
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int unsigned NSQ = DIST_W;
    localparam int unsigned NDV = 8;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [23:0]      r_world_size;
    logic [23:0]      r_base_dist;
    logic [MUL_W-1:0] r_mult;
    logic [MR_W-1:0]  r_morph_range;
    logic             r_morph_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_world_size  <= WORLD_SIZE_RST;
            r_base_dist   <= BASE_DIST_RST;
            r_mult        <= MULT_RST;
            r_morph_range <= MORPH_RANGE_RST;
            r_morph_en    <= MORPH_EN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WORLD_SIZE:  r_world_size  <= i_cfg_data;
                CFG_BASE_DIST:   r_base_dist   <= i_cfg_data;
                CFG_MULTIPLIER:  r_mult        <= i_cfg_data[MUL_W-1:0];
                CFG_MORPH_RANGE: r_morph_range <= i_cfg_data[MR_W-1:0];
                CFG_MORPH_EN:    r_morph_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp multiplier up to one and morph range down to one
    logic [MUL_W-1:0] w_mult;
    logic [MR_W-1:0]  w_mr;
    logic [MR_W-1:0]  w_inv_mr;

    assign w_mult   = (r_mult < MUL_ONE) ? MUL_ONE : r_mult;
    assign w_mr     = (r_morph_range > ONE_FX) ? ONE_FX : r_morph_range;
    assign w_inv_mr = ONE_FX - w_mr;

    // ------------------------------------------------------------------
    // Global advance: the pipe moves when the output register can take data
    // ------------------------------------------------------------------
    logic r_o_vld;
    logic w_adv;

    assign w_adv         = !r_o_vld || m_axis_tready;
    // hold off input transactions while in reset
    assign s_axis_tready = w_adv && i_rst_n;

    // ------------------------------------------------------------------
    // Front stage 0: unpack, differences, cull limit, threshold seed
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] w_nx, w_nz, w_size, w_cx, w_cz;
    logic [LVL_W-1:0]   w_lvl_in, w_lvl;
    logic [DIST_W-1:0]  w_dx, w_dz, w_adx, w_adz;
    logic [33:0]        w_lim_full;
    t_side              n_f0_side;

    assign w_nx     = s_axis_tdata[23:0];
    assign w_nz     = s_axis_tdata[47:24];
    assign w_size   = s_axis_tdata[71:48];
    assign w_lvl_in = s_axis_tdata[75:72];
    assign w_cx     = s_axis_tdata[99:76];
    assign w_cz     = s_axis_tdata[123:100];

    always_comb begin
        w_dx  = {w_nx[COORD_W-1], w_nx} - {w_cx[COORD_W-1], w_cx};
        w_dz  = {w_nz[COORD_W-1], w_nz} - {w_cz[COORD_W-1], w_cz};
        w_adx = w_dx[DIST_W-1] ? (~w_dx + DIST_W'(1)) : w_dx;
        w_adz = w_dz[DIST_W-1] ? (~w_dz + DIST_W'(1)) : w_dz;
        // dist*256 > limit is the same as dist > floor(limit/256)
        w_lim_full = 34'(r_world_size) * 34'd384 + 34'(w_size) * 34'd181;
        w_lvl = (w_lvl_in > LVL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : w_lvl_in;
        n_f0_side.lvl = w_lvl;
        n_f0_side.t   = THR_W'(r_base_dist);
        n_f0_side.thr = THR_W'(r_base_dist);
        n_f0_side.nxt = (w_lvl == LVL_W'(1)) ? THR_W'(r_base_dist) : '0;
        n_f0_side.lim = w_lim_full[33:8];
    end

    logic              r_f0_vld, r_f1_vld, r_f2_vld;
    logic [DIST_W-1:0] r_f0_adx, r_f0_adz;
    logic [RAD_W-1:0]  r_f1_sqx, r_f1_sqz, r_f2_sum;
    t_side             r_f0_side, r_f1_side, r_f2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_vld <= 1'b0;
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
        end else if (w_adv) begin
            r_f0_vld <= s_axis_tvalid;
            r_f1_vld <= r_f0_vld;
            r_f2_vld <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f0_adx  <= w_adx;
            r_f0_adz  <= w_adz;
            r_f0_side <= n_f0_side;
            // squares; sum cannot exceed 50 bits
            r_f1_sqx  <= RAD_W'(r_f0_adx) * RAD_W'(r_f0_adx);
            r_f1_sqz  <= RAD_W'(r_f0_adz) * RAD_W'(r_f0_adz);
            r_f1_side <= r_f0_side;
            r_f2_sum  <= r_f1_sqx + r_f1_sqz;
            r_f2_side <= r_f1_side;
        end
    end

    // ------------------------------------------------------------------
    // Square root, one result bit per stage; threshold growth alongside
    // ------------------------------------------------------------------
    logic              w_sq_vld  [0:NSQ];
    logic [RAD_W-1:0]  w_sq_rem  [0:NSQ];
    logic [DIST_W-1:0] w_sq_root [0:NSQ];
    t_side             w_sq_side [0:NSQ];

    assign w_sq_vld[0]  = r_f2_vld;
    assign w_sq_rem[0]  = r_f2_sum;
    assign w_sq_root[0] = '0;
    assign w_sq_side[0] = r_f2_side;

    for (genvar i = 0; i < NSQ; i++) begin : g_sq
        tqlod_stage #(
            .BIT  (NSQ - 1 - i),
            .STEP ((i + 1 <= MAX_LEVEL) ? (i + 1) : 0)
        ) u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (w_adv),
            .i_mult (w_mult),
            .i_vld  (w_sq_vld[i]),
            .i_rem  (w_sq_rem[i]),
            .i_root (w_sq_root[i]),
            .i_side (w_sq_side[i]),
            .o_vld  (w_sq_vld[i+1]),
            .o_rem  (w_sq_rem[i+1]),
            .o_root (w_sq_root[i+1]),
            .o_side (w_sq_side[i+1])
        );
    end

    logic [DIST_W-1:0] w_dist;
    t_side             w_side;

    assign w_dist = w_sq_root[NSQ];
    assign w_side = w_sq_side[NSQ];

    // ------------------------------------------------------------------
    // Morph start: A decides cull/split, B scales the band, C adds the
    // finer threshold, D forms numerator and denominator
    // ------------------------------------------------------------------
    logic              r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    logic              r_a_vis, r_b_vis, r_c_vis, r_d_vis;
    logic              r_a_split, r_b_split, r_c_split, r_d_split;
    logic [DIST_W-1:0] r_a_dist, r_b_dist, r_c_dist, r_d_dist;
    logic [THR_W-1:0]  r_a_thr, r_b_thr, r_c_thr, r_d_thr;
    logic [THR_W-1:0]  r_a_nxt, r_b_nxt;
    logic [THR_W-1:0]  r_a_diff;
    logic [THR_W+MR_W-1:0] r_b_prod;
    logic [THR_W-1:0]  r_c_start;
    logic              r_d_act;
    logic [DIST_W-1:0] r_d_num;
    logic [THR_W-1:0]  r_d_den;
    logic              n_a_vis;

    assign n_a_vis = ({1'b0, w_dist} <= w_side.lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld <= w_sq_vld[NSQ];
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_vis   <= n_a_vis;
            r_a_split <= n_a_vis && (w_side.lvl != '0)
                         && (THR_W'(w_dist) < w_side.thr);
            r_a_dist  <= w_dist;
            r_a_thr   <= w_side.thr;
            r_a_nxt   <= w_side.nxt;
            r_a_diff  <= w_side.thr - w_side.nxt;

            r_b_vis   <= r_a_vis;
            r_b_split <= r_a_split;
            r_b_dist  <= r_a_dist;
            r_b_thr   <= r_a_thr;
            r_b_nxt   <= r_a_nxt;
            r_b_prod  <= (THR_W+MR_W)'(r_a_diff) * (THR_W+MR_W)'(w_inv_mr);

            r_c_vis   <= r_b_vis;
            r_c_split <= r_b_split;
            r_c_dist  <= r_b_dist;
            r_c_thr   <= r_b_thr;
            // scaled band never exceeds the band itself, so 32 bits hold it
            r_c_start <= r_b_nxt + r_b_prod[THR_W+7:8];

            r_d_vis   <= r_c_vis;
            r_d_split <= r_c_split;
            r_d_dist  <= r_c_dist;
            r_d_thr   <= r_c_thr;
            r_d_act   <= r_c_vis && !r_c_split && r_morph_en
                         && (THR_W'(r_c_dist) > r_c_start);
            r_d_num   <= r_c_dist - r_c_start[DIST_W-1:0];
            r_d_den   <= r_c_thr - r_c_start;
        end
    end

    // ------------------------------------------------------------------
    // Fractional divide: stage 0 flags saturation, then one quotient bit
    // per stage
    // ------------------------------------------------------------------
    logic  r_dv_vld [0:NDV];
    t_div  r_dv     [0:NDV];
    t_div  n_dv0;

    always_comb begin
        n_dv0.vis   = r_d_vis;
        n_dv0.split = r_d_split;
        n_dv0.cdist = r_d_dist;
        n_dv0.thr   = r_d_thr;
        n_dv0.act   = r_d_act;
        // zero denominator or ratio of one or more both give full blend
        n_dv0.full  = (r_d_den == '0) || (THR_W'(r_d_num) >= r_d_den);
        n_dv0.den   = r_d_den;
        n_dv0.rem   = THR_W'(r_d_num);
        n_dv0.q     = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_dv_vld[0] <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv[0] <= n_dv0;
        end
    end

    for (genvar j = 1; j <= NDV; j++) begin : g_dv
        logic [THR_W:0] w_r2;
        t_div           n_dv;

        always_comb begin
            n_dv = r_dv[j-1];
            w_r2 = {r_dv[j-1].rem, 1'b0};
            if (w_r2 >= {1'b0, r_dv[j-1].den}) begin
                n_dv.rem = THR_W'(w_r2 - {1'b0, r_dv[j-1].den});
                n_dv.q   = {r_dv[j-1].q[6:0], 1'b1};
            end else begin
                n_dv.rem = w_r2[THR_W-1:0];
                n_dv.q   = {r_dv[j-1].q[6:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j] <= 1'b0;
            end else if (w_adv) begin
                r_dv_vld[j] <= r_dv_vld[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv[j] <= n_dv;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    t_div             w_last;
    logic [MR_W-1:0]  n_morph;
    logic             r_o_vis, r_o_split;
    logic [DIST_W-1:0] r_o_dist;
    logic [THR_W-1:0] r_o_thr;
    logic [MR_W-1:0]  r_o_morph;

    assign w_last = r_dv[NDV];

    always_comb begin
        if (!w_last.act) begin
            n_morph = '0;
        end else if (w_last.full) begin
            n_morph = ONE_FX;
        end else begin
            n_morph = {1'b0, w_last.q};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_adv) begin
            r_o_vld <= r_dv_vld[NDV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_vis   <= w_last.vis;
            r_o_split <= w_last.split;
            r_o_dist  <= w_last.cdist;
            r_o_thr   <= w_last.thr;
            r_o_morph <= n_morph;
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = {4'b0000, r_o_morph, r_o_thr, r_o_dist, r_o_split, r_o_vis};

endmodule

// ===== rtl/tqlod_checker.sv =====
// ----------------------------------------------------------------------------
// tqlod_checker
// Port-level checks on classifier results, bound to the top level.
// ----------------------------------------------------------------------------
module tqlod_checker import tqlod_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic             w_vis, w_split;
    logic [DIST_W-1:0] w_dist;
    logic [THR_W-1:0] w_thr;
    logic [MR_W-1:0]  w_morph;

    assign w_vis   = m_axis_tdata[0];
    assign w_split = m_axis_tdata[1];
    assign w_dist  = m_axis_tdata[26:2];
    assign w_thr   = m_axis_tdata[58:27];
    assign w_morph = m_axis_tdata[67:59];

    a_cull_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !w_vis) |-> (!w_split && (w_morph == '0)))
        else $error("culled node carries split or morph");

    a_split_no_morph : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_split) |-> (w_morph == '0))
        else $error("splitting node carries morph");

    a_split_near : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_split) |-> (THR_W'(w_dist) < w_thr))
        else $error("split with distance past threshold");

    a_morph_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_morph <= ONE_FX))
        else $error("morph factor above one");

endmodule

bind terrain_quad_lod_classifier tqlod_checker u_tqlod_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tdata (m_axis_tdata)
);

// ===== tb/tb_terrain_quad_lod_classifier.sv =====
// ----------------------------------------------------------------------------
// tb_terrain_quad_lod_classifier
// Self-checking bench for the quadtree LOD classifier. Node transactions go in
// on s_axis and the bench computes visibility, split, distance, level threshold
// and geomorph factor for each one. Results from m_axis are compared with them
// in order. Configuration changes between phases, only while the pipe is empty.
// ----------------------------------------------------------------------------
module tb_terrain_quad_lod_classifier import tqlod_pkg::*; ();

    typedef struct {
        logic signed [23:0] nx;
        logic signed [23:0] nz;
        logic [23:0]        size;
        logic [3:0]         lvl;
        logic signed [23:0] cx;
        logic signed [23:0] cz;
    } t_node;

    typedef struct {
        logic        vis;
        logic        split;
        logic [24:0] cdist;
        logic [31:0] thr;
        logic [8:0]  morph;
    } t_lod;

    // Classification model plus the queue of outstanding classifications
    class t_scoreboard;
        longint unsigned world, base, mult, mrange, men;
        t_lod            pending[$];
        int              errors;

        function new();
            world = WORLD_SIZE_RST; base = BASE_DIST_RST; mult = MULT_RST;
            mrange = MORPH_RANGE_RST; men = MORPH_EN_RST;
            errors = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [23:0] v);
            case (idx)
                CFG_WORLD_SIZE:  world  = v;
                CFG_BASE_DIST:   base   = v;
                CFG_MULTIPLIER:  mult   = v[11:0];
                CFG_MORPH_RANGE: mrange = v[8:0];
                CFG_MORPH_EN:    men    = v[0];
                default: ;
            endcase
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 50;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // base * multiplier^level, saturating at every level step
        function longint unsigned lvl_thr(int lv);
            longint unsigned m, t;
            m = (mult < 256) ? 256 : mult;
            t = base;
            for (int i = 0; i < lv; i++) begin
                t = (t * m) >> 8;
                if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
            end
            return t;
        endfunction

        function void note_node(t_node n);
            longint          dx, dz;
            longint unsigned adx, adz, d, lim, thr, nxt, r, st, mf;
            t_lod            e;
            dx  = longint'(n.nx) - longint'(n.cx);
            dz  = longint'(n.nz) - longint'(n.cz);
            adx = (dx < 0) ? -dx : dx;
            adz = (dz < 0) ? -dz : dz;
            d   = root(adx * adx + adz * adz);
            lim = world * 384 + longint'(n.size) * 181;
            e.vis   = !(d * 256 > lim);
            thr     = lvl_thr(n.lvl);
            e.split = e.vis && n.lvl != 0 && d < thr;
            mf = 0;
            if (e.vis && !e.split && men != 0) begin
                nxt = (n.lvl > 0) ? lvl_thr(n.lvl - 1) : 0;
                r   = (mrange > 256) ? 256 : mrange;
                st  = nxt + (((thr - nxt) * (256 - r)) >> 8);
                if (d > st) begin
                    if (thr == st) begin
                        mf = 256;
                    end else begin
                        mf = ((d - st) * 256) / (thr - st);
                        if (mf > 256) mf = 256;
                    end
                end
            end
            e.cdist = d[24:0];
            e.thr   = thr[31:0];
            e.morph = mf[8:0];
            pending = {pending, e};
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] d);
            t_lod e, a;
            a.vis = d[0]; a.split = d[1]; a.cdist = d[26:2];
            a.thr = d[58:27]; a.morph = d[67:59];
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", d);
                return;
            end
            e = pending.pop_front();
            if (a.vis !== e.vis || a.split !== e.split || a.cdist !== e.cdist ||
                a.thr !== e.thr || a.morph !== e.morph) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch exp vis %0d sub %0d dist %0d thr %0d morph %0d",
                              " / got vis %0d sub %0d dist %0d thr %0d morph %0d"},
                             e.vis, e.split, e.cdist, e.thr, e.morph,
                             a.vis, a.split, a.cdist, a.thr, a.morph);
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [IDX_W-1:0]       i_cfg_idx = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    t_scoreboard   sb = new();
    bit            idle_on = 1'b1;   // random gaps on both sides
    bit            hold_req = 1'b0;  // ask the receiver for a long hold-off
    int            cycles = 0;

    terrain_quad_lod_classifier dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: far above the slowest legal run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("tb_terrain_quad_lod_classifier: errors");
            $finish;
        end
    end

    // Check every result transaction as it leaves
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // Receiver: random back-pressure bursts, plus one long stall on request
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Write one register; the caller drops the write enable after the last one
    task automatic cfg_write(t_cfg_idx idx, logic [23:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_reg(idx, v);
    endtask

    task automatic cfg_all(logic [23:0] w, logic [23:0] b, logic [11:0] m,
                           logic [8:0] r, logic e);
        cfg_write(CFG_WORLD_SIZE, w);
        cfg_write(CFG_BASE_DIST, b);
        cfg_write(CFG_MULTIPLIER, {12'd0, m});
        cfg_write(CFG_MORPH_RANGE, {15'd0, r});
        cfg_write(CFG_MORPH_EN, {23'd0, e});
        i_cfg_we <= 1'b0;
    endtask

    // Hold input until every outstanding result has arrived, then let the
    // pipe run dry
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic send_node(t_node n);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, n.cz, n.cx, n.lvl, n.size, n.nz, n.nx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_node(n);
    endtask

    function automatic logic signed [23:0] clip24(longint v);
        if (v > 8388607) return 24'sd8388607;
        if (v < -8388608) return -24'sd8388608;
        return v[23:0];
    endfunction

    // Half the nodes sit near a level band edge so the split and morph
    // decisions are exercised; a quarter sit at varied offsets; the rest is full-range noise
    function automatic t_node rand_node();
        t_node  n;
        longint tgt, ang, ofs;
        n.nx = 24'($urandom); n.nz = 24'($urandom);
        n.cx = 24'($urandom); n.cz = 24'($urandom);
        n.size = 24'($urandom); n.lvl = 4'($urandom);
        case ($urandom_range(0, 3))
            0: ;
            1: begin
                n.size = 24'($urandom_range(0, 1 << $urandom_range(0, 23)));
                n.nx   = 24'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
                n.nz   = 24'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
                ofs    = longint'($urandom_range(0, 1 << $urandom_range(0, 22)));
                if ($urandom_range(0, 1) != 0) ofs = -ofs;
                n.cx   = clip24(longint'(n.nx) + longint'($urandom_range(0, 1 << 16))
                                - (1 << 15) + ofs);
                n.cz   = clip24(longint'(n.nz) + longint'($urandom_range(0, 1 << 12))
                                - (1 << 11));
            end
            default: begin
                n.size = 24'($urandom_range(0, 1 << 16));
                tgt = longint'(sb.lvl_thr(n.lvl));
                tgt = (tgt * longint'($urandom_range(128, 300))) >> 8;
                tgt = tgt + longint'($urandom_range(0, 8)) - 4;
                if (tgt > 8000000) tgt = longint'($urandom_range(0, 8000000));
                ang = longint'($urandom_range(0, 255));
                n.nx = 24'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
                n.nz = 24'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
                n.cx = clip24(longint'(n.nx) + ((tgt * ang) >> 8));
                n.cz = clip24(longint'(n.nz) - ((tgt * (256 - ang)) >> 9));
            end
        endcase
        return n;
    endfunction

    task automatic directed_nodes();
        t_node n;
        // camera on the node centre, finest and coarsest levels
        n = '{0, 0, 0, 0, 0, 0};                  send_node(n);
        n.lvl = 4'd15;                            send_node(n);
        // largest separation in both axes, largest and smallest size
        n = '{-24'sd8388608, -24'sd8388608, 24'hFFFFFF, 4'd15,
              24'sd8388607, 24'sd8388607};        send_node(n);
        n.size = '0; n.lvl = '0;                  send_node(n);
        n = '{24'sd8388607, 24'sd8388607, 0, 4'd7, -24'sd8388608, -24'sd8388608};
        send_node(n);
        // distance exactly at and around the level thresholds
        for (int lv = 0; lv < 4; lv++) begin
            for (int k = -1; k <= 1; k++) begin
                n = '{0, 0, 24'd256, lv[3:0], 0, 0};
                n.cx = clip24(longint'(sb.lvl_thr(lv)) + k);
                send_node(n);
            end
        end
        // inside the morph band of a leaf, and a coarse node inside its split distance
        n = '{0, 0, 24'd256, 4'd0, 24'sd24000, 0}; send_node(n);
        n = '{0, 0, 24'd256, 4'd2, 24'sd90000, 0}; send_node(n);
        // just inside the cull radius, and just past it
        n = '{0, 0, 0, 4'd1, 24'sd393216, 0};      send_node(n);
        n = '{0, 0, 0, 4'd1, 24'sd393217, 0};      send_node(n);
        n = '{0, 0, 24'hFFFFFF, 4'd0, -24'sd8388608, 24'sd8388607}; send_node(n);
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) send_node(rand_node());
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults
        directed_nodes();
        random_phase(150);

        // Long receiver stall while the sender keeps offering
        idle_on  = 1'b0;
        hold_req = 1'b1;
        random_phase(120);
        idle_on  = 1'b1;
        random_phase(60);

        // Largest settings: upper-level thresholds saturate, nothing is culled
        drain();
        cfg_all(24'hFFFFFF, 24'hFFFFFF, 12'd4095, 9'd256, 1'b1);
        directed_nodes();
        random_phase(150);

        // Smallest settings: zero thresholds, zero morph band
        drain();
        cfg_all(24'd0, 24'd0, 12'd256, 9'd0, 1'b1);
        random_phase(120);

        // Multiplier below one and morph range above one are clamped
        drain();
        cfg_all(24'd40000, 24'd3000, 12'd100, 9'd511, 1'b1);
        directed_nodes();
        random_phase(110);

        // Morphing off
        drain();
        cfg_all(24'd262144, 24'd25600, 12'd384, 9'd128, 1'b0);
        random_phase(120);

        // Random settings
        for (int p = 0; p < 2; p++) begin
            drain();
            cfg_all(24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 12)),
                    24'($urandom_range(0, 24'hFFFF)), 12'($urandom_range(256, 4095)),
                    9'($urandom_range(0, 256)), 1'b1);
            random_phase(120);
        end

        // Tail with no gaps on either side
        idle_on = 1'b0;
        random_phase(120);
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_terrain_quad_lod_classifier: clean");
        end else begin
            $display("tb_terrain_quad_lod_classifier: errors");
        end
        $finish;
    end

endmodule
